### rtl/sia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, codes and the microprogram of the signed integer ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int SIA_WORD_BITS  = 32;
  localparam int SIA_UADDR_BITS = 5;

  typedef logic [SIA_UADDR_BITS-1:0] uaddr_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_REM = 3'd5
  } op_e;

  // datapath action for one microstep
  typedef enum logic [3:0] {
    ACT_NOP      = 4'd0,
    ACT_ADD      = 4'd1,
    ACT_SUB      = 4'd2,
    ACT_MUL_INIT = 4'd3,
    ACT_MUL_STEP = 4'd4,
    ACT_RES_ACC  = 4'd5,
    ACT_DIV_INIT = 4'd6,
    ACT_DIV_STEP = 4'd7,
    ACT_RES_QUO  = 4'd8,
    ACT_RES_REM  = 4'd9,
    ACT_POW_INIT = 4'd10,
    ACT_POW_UPD  = 4'd11,
    ACT_RES_A    = 4'd12,
    ACT_RES_ERR  = 4'd13,
    ACT_RES_ZERO = 4'd14
  } act_e;

  // jump condition
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_CNT_MORE = 3'd2,
    C_B_ZERO   = 3'd3,
    C_B_NEG    = 3'd4,
    C_E_ZERO   = 3'd5
  } cond_e;

  typedef struct packed {
    act_e   act;
    cond_e  cond;
    uaddr_t target;
    logic   done;
  } ucode_t;

  typedef struct packed {
    logic cnt_more;
    logic b_zero;
    logic b_neg;
    logic e_zero;
  } dp_status_t;

  // microprogram addresses
  localparam uaddr_t UA_ADD      = 5'd0;
  localparam uaddr_t UA_SUB      = 5'd1;
  localparam uaddr_t UA_MUL      = 5'd2;
  localparam uaddr_t UA_MUL_LOOP = 5'd3;
  localparam uaddr_t UA_MUL_END  = 5'd4;
  localparam uaddr_t UA_DIV      = 5'd5;
  localparam uaddr_t UA_DIV_INIT = 5'd6;
  localparam uaddr_t UA_DIV_LOOP = 5'd7;
  localparam uaddr_t UA_DIV_END  = 5'd8;
  localparam uaddr_t UA_REM      = 5'd9;
  localparam uaddr_t UA_REM_INIT = 5'd10;
  localparam uaddr_t UA_REM_LOOP = 5'd11;
  localparam uaddr_t UA_REM_END  = 5'd12;
  localparam uaddr_t UA_POW      = 5'd13;
  localparam uaddr_t UA_POW_INIT = 5'd14;
  localparam uaddr_t UA_POW_TEST = 5'd15;
  localparam uaddr_t UA_POW_MUL  = 5'd16;
  localparam uaddr_t UA_POW_LOOP = 5'd17;
  localparam uaddr_t UA_POW_UPD  = 5'd18;
  localparam uaddr_t UA_RES_A    = 5'd19;
  localparam uaddr_t UA_ERR      = 5'd20;
  localparam uaddr_t UA_ZERO     = 5'd21;
  localparam uaddr_t UA_LAST     = UA_ZERO;

  function automatic ucode_t uw(act_e act, cond_e cond, uaddr_t target, logic done);
    ucode_t w;
    w.act    = act;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  function automatic ucode_t sia_ucode(uaddr_t addr);
    ucode_t w;
    case (addr)
      UA_ADD:      w = uw(ACT_ADD,      C_NEVER,    UA_ADD,      1'b1);
      UA_SUB:      w = uw(ACT_SUB,      C_NEVER,    UA_ADD,      1'b1);
      UA_MUL:      w = uw(ACT_MUL_INIT, C_NEVER,    UA_ADD,      1'b0);
      UA_MUL_LOOP: w = uw(ACT_MUL_STEP, C_CNT_MORE, UA_MUL_LOOP, 1'b0);
      UA_MUL_END:  w = uw(ACT_RES_ACC,  C_NEVER,    UA_ADD,      1'b1);
      UA_DIV:      w = uw(ACT_NOP,      C_B_ZERO,   UA_ERR,      1'b0);
      UA_DIV_INIT: w = uw(ACT_DIV_INIT, C_NEVER,    UA_ADD,      1'b0);
      UA_DIV_LOOP: w = uw(ACT_DIV_STEP, C_CNT_MORE, UA_DIV_LOOP, 1'b0);
      UA_DIV_END:  w = uw(ACT_RES_QUO,  C_NEVER,    UA_ADD,      1'b1);
      UA_REM:      w = uw(ACT_NOP,      C_B_ZERO,   UA_RES_A,    1'b0);
      UA_REM_INIT: w = uw(ACT_DIV_INIT, C_NEVER,    UA_ADD,      1'b0);
      UA_REM_LOOP: w = uw(ACT_DIV_STEP, C_CNT_MORE, UA_REM_LOOP, 1'b0);
      UA_REM_END:  w = uw(ACT_RES_REM,  C_NEVER,    UA_ADD,      1'b1);
      UA_POW:      w = uw(ACT_NOP,      C_B_NEG,    UA_ERR,      1'b0);
      UA_POW_INIT: w = uw(ACT_POW_INIT, C_NEVER,    UA_ADD,      1'b0);
      UA_POW_TEST: w = uw(ACT_NOP,      C_E_ZERO,   UA_RES_A,    1'b0);
      UA_POW_MUL:  w = uw(ACT_MUL_INIT, C_NEVER,    UA_ADD,      1'b0);
      UA_POW_LOOP: w = uw(ACT_MUL_STEP, C_CNT_MORE, UA_POW_LOOP, 1'b0);
      UA_POW_UPD:  w = uw(ACT_POW_UPD,  C_ALWAYS,   UA_POW_TEST, 1'b0);
      UA_RES_A:    w = uw(ACT_RES_A,    C_NEVER,    UA_ADD,      1'b1);
      UA_ERR:      w = uw(ACT_RES_ERR,  C_NEVER,    UA_ADD,      1'b1);
      default:     w = uw(ACT_RES_ZERO, C_NEVER,    UA_ADD,      1'b1);
    endcase
    return w;
  endfunction

  // entry point of each operation; unused codes land on the zero result
  function automatic uaddr_t sia_entry(logic [2:0] op);
    uaddr_t a;
    case (op)
      OP_ADD:  a = UA_ADD;
      OP_SUB:  a = UA_SUB;
      OP_MUL:  a = UA_MUL;
      OP_DIV:  a = UA_DIV;
      OP_POW:  a = UA_POW;
      OP_REM:  a = UA_REM;
      default: a = UA_ZERO;
    endcase
    return a;
  endfunction

endpackage

### rtl/sia_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_datapath
// Operand registers, shift-add multiplier with a squaring lane and
// restoring divider, driven one microstep at a time.
// ----------------------------------------------------------------------------
module sia_datapath
  import sia_pkg::*;
#(
  parameter int WORD_BITS = SIA_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic signed [31:0]   operand_a_i,
  input  logic signed [31:0]   operand_b_i,
  input  logic                 step_i,
  input  ucode_t               uword_i,
  output dp_status_t           status_o,
  output logic [WORD_BITS-1:0] res_o,
  output logic                 err_o
);

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] ra_q, rb_q, re_q, m_q, pa_q, sa_q, acc_q, sq_q;
  logic [CW-1:0]        cnt_q;
  logic                 na_q, nb_q;

  logic [WORD_BITS-1:0] abs_a, abs_b;
  logic [WORD_BITS:0]   rem_sh, diff;
  logic                 qbit;

  assign abs_a  = ra_q[WORD_BITS-1] ? (~ra_q + 1'b1) : ra_q;
  assign abs_b  = rb_q[WORD_BITS-1] ? (~rb_q + 1'b1) : rb_q;
  assign rem_sh = {acc_q, m_q[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, pa_q};
  assign qbit   = ~diff[WORD_BITS];

  assign status_o.cnt_more = (cnt_q != CW'(WORD_BITS - 1));
  assign status_o.b_zero   = (rb_q == '0);
  assign status_o.b_neg    = rb_q[WORD_BITS-1];
  assign status_o.e_zero   = (re_q == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ra_q <= WORD_BITS'(operand_a_i);
      rb_q <= WORD_BITS'(operand_b_i);
    end else if (step_i) begin
      case (uword_i.act)
        ACT_MUL_INIT: begin
          m_q   <= rb_q;
          pa_q  <= ra_q;
          sa_q  <= rb_q;
          acc_q <= '0;
          sq_q  <= '0;
          cnt_q <= '0;
        end
        ACT_MUL_STEP: begin
          if (m_q[0]) begin
            acc_q <= acc_q + pa_q;
            sq_q  <= sq_q + sa_q;
          end
          m_q   <= m_q >> 1;
          pa_q  <= pa_q << 1;
          sa_q  <= sa_q << 1;
          cnt_q <= cnt_q + 1'b1;
        end
        ACT_POW_INIT: begin
          re_q <= rb_q;
          rb_q <= ra_q;
          ra_q <= WORD_BITS'(1);
        end
        ACT_POW_UPD: begin
          if (re_q[0]) begin
            ra_q <= acc_q;
          end
          rb_q <= sq_q;
          re_q <= re_q >> 1;
        end
        ACT_DIV_INIT: begin
          na_q  <= ra_q[WORD_BITS-1];
          nb_q  <= rb_q[WORD_BITS-1];
          m_q   <= abs_a;
          pa_q  <= abs_b;
          acc_q <= '0;
          cnt_q <= '0;
        end
        ACT_DIV_STEP: begin
          acc_q <= qbit ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
          m_q   <= {m_q[WORD_BITS-2:0], qbit};
          cnt_q <= cnt_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    err_o = 1'b0;
    case (uword_i.act)
      ACT_ADD:     res_o = ra_q + rb_q;
      ACT_SUB:     res_o = ra_q - rb_q;
      ACT_RES_ACC: res_o = acc_q;
      ACT_RES_QUO: res_o = (na_q ^ nb_q) ? (~m_q + 1'b1) : m_q;
      ACT_RES_REM: res_o = na_q ? (~acc_q + 1'b1) : acc_q;
      ACT_RES_A:   res_o = ra_q;
      ACT_RES_ERR: err_o = 1'b1;
      default:     res_o = '0;
    endcase
  end

endmodule

### rtl/signed_integer_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_alu_core
// Microcoded signed integer ALU: add, subtract, multiply, divide, power and
// remainder on two's complement operands, wrapping modulo 2^WORD_BITS.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                          tuser
//  s_axis    in         [31:0] operand_a, [63:32] b    [2:0] op
//  m_axis    out        [31:0] result                  [0] error
//
// Steps: the item is accepted when idle, then the microprogram runs. Add,
// subtract and unused codes finish in their entry step; multiply runs init,
// a shift-add loop over every bit and a result step; divide and remainder
// check for a zero divisor, then init, one quotient bit per step and result;
// power makes one squaring pass per exponent bit. The divider is restoring.
// Reset: clears the sequencer and the output valid flag; no clearing pass.
// Stalls: a finished result waits in the output register; a new item is
// taken meanwhile, and its last step holds only if that register is full.
//
module signed_integer_alu_core
  import sia_pkg::*;
#(
  parameter int WORD_BITS = SIA_WORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result
  output logic        m_axis_tuser    // [0] error
);

  // sequencer state
  logic   busy_q, busy_d;
  uaddr_t upc_q, upc_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_err_q, out_err_d;

  ucode_t               uword;
  dp_status_t           status;
  logic [WORD_BITS-1:0] dp_res;
  logic                 dp_err;
  logic                 accept, hold, step_en, taken;

  // fetch the current control word
  assign uword = sia_ucode(upc_q);

  assign s_axis_tready = ~busy_q;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // hold the final step while the previous result is still unclaimed
  assign hold    = uword.done & out_valid_q & ~m_axis_tready;
  assign step_en = busy_q & ~hold;

  always_comb begin
    case (uword.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_CNT_MORE: taken = status.cnt_more;
      C_B_ZERO:   taken = status.b_zero;
      C_B_NEG:    taken = status.b_neg;
      C_E_ZERO:   taken = status.e_zero;
      default:    taken = 1'b0;
    endcase
  end

  // load the entry point on accept; else advance the micro PC, jump, or drop back to idle
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (accept) begin
      busy_d = 1'b1;
      upc_d  = sia_entry(s_axis_tuser);
    end else if (step_en) begin
      if (uword.done) begin
        busy_d = 1'b0;
      end else if (taken) begin
        upc_d = uword.target;
      end else begin
        upc_d = uaddr_t'(upc_q + 1'b1);
      end
    end
  end

  // load the output register on the last step; clear valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;
    if (step_en && uword.done) begin
      out_valid_d = 1'b1;
      out_data_d  = 32'(dp_res);
      out_err_d   = dp_err;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UA_ADD;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  sia_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .load_i      (accept),
    .operand_a_i (s_axis_tdata[31:0]),
    .operand_b_i (s_axis_tdata[63:32]),
    .step_i      (step_en),
    .uword_i     (uword),
    .status_o    (status),
    .res_o       (dp_res),
    .err_o       (dp_err)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  // the micro PC never leaves the microprogram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (upc_q <= UA_LAST))
    else $error("micro PC outside the program");

  // a last step that is not held always delivers a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && uword.done |=> m_axis_tvalid && !busy_q)
    else $error("final step did not deliver a result");

  // an error result carries a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("error result with non-zero data");

  // a running program stays busy until its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !uword.done |=> busy_q)
    else $error("sequencer went idle before its last step");

endmodule
